// ----- hw/rtl/unaligned_byte_addressed_word_store_assert.svh -----
// Assertion macros shared by the word store controller and datapath.
// Expects clk_i and rst_ni in the scope of use.
`ifndef UNALIGNED_BYTE_ADDRESSED_WORD_STORE_ASSERT_SVH
`define UNALIGNED_BYTE_ADDRESSED_WORD_STORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UBWS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("word store assertion failed");

// antecedent implies consequent in the next cycle
`define UBWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("word store assertion failed");

`endif

// ----- hw/rtl/ubws_pkg.sv -----
// Package for the unaligned byte-addressed word store.
// Transfer types, controller states, command/status structs, size helpers.
package ubws_pkg;

  localparam int LANES  = 4;
  localparam int BYTE_W = 8;
  localparam int DATA_W = LANES * BYTE_W;
  localparam int ADDR_W = 8;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        access_size;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              range_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_WHI,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ADDR_IN,
    ADDR_W0,
    ADDR_W1,
    ADDR_CLR
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_ZERO,
    WSEL_LO,
    WSEL_HI
  } wsel_e;

  typedef struct packed {
    logic      latch;
    logic      mem_en;
    logic      mem_we;
    addr_sel_e addr_sel;
    wsel_e     wsel;
    logic      cap_lo;
    logic      cap_hi;
    logic      out_load;
    logic      clr_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_err;
    logic straddle;
    logic is_write;
    logic clr_last;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [2:0] size_bytes(logic [1:0] size);
    logic [2:0] n;
    if (size[1]) begin
      n = 3'd4;
    end else if (size == SIZE_HALF) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] size_mask(logic [1:0] size);
    logic [DATA_W-1:0] m;
    if (size[1]) begin
      m = '1;
    end else if (size == SIZE_HALF) begin
      m = DATA_W'(16'hFFFF);
    end else begin
      m = DATA_W'(8'hFF);
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/ubws_datapath.sv -----
// Datapath of the word store: item registers, single-port word memory,
// byte merge and extract, clear counter, result register. Uses ubws_pkg.
module ubws_datapath import ubws_pkg::*; #(
  parameter int WORDS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_data_i,
  input  ctrl_cmd_t    cmd_i,
  output ctrl_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_data_o
);

  // byte addresses reach word 64 through the top lane of a straddling word access
  localparam int Depth = (WORDS < 65) ? WORDS : 65;
  localparam int AW    = $clog2(Depth);
  localparam logic [18:0] LimitW = 19'(WORDS * LANES);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  logic              cmd_q;
  logic [1:0]        size_q;
  logic [1:0]        lane_q;
  logic [AW-1:0]     w0_q;
  logic [DATA_W-1:0] data_q;
  logic              err_q;
  logic              straddle_q;
  logic [DATA_W-1:0] lo_q, hi_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [2:0]        in_nb;
  logic [18:0]       in_end;
  logic              in_err;
  logic              in_straddle;
  logic [AW-1:0]     in_w0;
  logic [AW-1:0]     w1;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] lo_src, hi_src;
  logic [4:0]        sh;
  logic [DATA_W-1:0] smask;
  logic [2*DATA_W-1:0] m64, d64, merged, rd64;
  logic [DATA_W-1:0] rd_val;
  logic              out_free;

  assign in_nb       = size_bytes(in_data_i.access_size);
  assign in_end      = 19'(in_data_i.byte_address) + 19'(in_nb);
  assign in_err      = in_end > LimitW;
  assign in_straddle = (4'(in_data_i.byte_address[1:0]) + 4'(in_nb)) > 4'(LANES);
  assign in_w0       = AW'(in_data_i.byte_address[ADDR_W-1:2]);

  assign w1 = w0_q + AW'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_IN:  mem_addr = in_w0;
      ADDR_W0:  mem_addr = w0_q;
      ADDR_W1:  mem_addr = w1;
      ADDR_CLR: mem_addr = clr_cnt_q;
      default:  mem_addr = clr_cnt_q;
    endcase
  end

  assign lo_src = cmd_i.cap_lo ? rdata_q : lo_q;
  assign hi_src = cmd_i.cap_hi ? rdata_q : hi_q;
  assign sh     = {lane_q, 3'b000};
  assign smask  = size_mask(size_q);
  assign m64    = {{DATA_W{1'b0}}, smask} << sh;
  assign d64    = {{DATA_W{1'b0}}, data_q & smask} << sh;
  assign merged = ({hi_src, lo_src} & ~m64) | d64;

  always_comb begin
    case (cmd_i.wsel)
      WSEL_LO:   mem_wdata = merged[DATA_W-1:0];
      WSEL_HI:   mem_wdata = merged[2*DATA_W-1:DATA_W];
      WSEL_ZERO: mem_wdata = '0;
      default:   mem_wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_en) begin
      if (cmd_i.mem_we) begin
        mem_q[mem_addr] <= mem_wdata;
      end else begin
        rdata_q <= mem_q[mem_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q      <= in_data_i.cmd;
      size_q     <= in_data_i.access_size;
      lane_q     <= in_data_i.byte_address[1:0];
      w0_q       <= in_w0;
      data_q     <= in_data_i.write_data;
      err_q      <= in_err;
      straddle_q <= in_straddle;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_inc) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign rd64   = {hi_q, lo_q} >> sh;
  assign rd_val = rd64[DATA_W-1:0] & smask;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.read_data   <= (cmd_q == CMD_WRITE || err_q) ? '0 : rd_val;
      out_q.range_error <= err_q;
    end
  end

  assign status_o.in_err   = in_err;
  assign status_o.straddle = straddle_q;
  assign status_o.is_write = cmd_q;
  assign status_o.clr_last = clr_cnt_q == AW'(Depth - 1);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "unaligned_byte_addressed_word_store_assert.svh"

  `UBWS_ASSERT_IMPL(a_no_mem_on_err, cmd_i.mem_en && cmd_i.addr_sel != ADDR_CLR && !cmd_i.latch, !err_q)
  `UBWS_ASSERT_IMPL(a_item_write_only, cmd_i.mem_we && cmd_i.wsel != WSEL_ZERO, cmd_q == CMD_WRITE)
  `UBWS_ASSERT_IMPL(a_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i)

endmodule

// ----- hw/rtl/ubws_ctrl.sv -----
// Controller of the word store: clear pass, read-modify-write sequencing
// over the single memory port, result hand-off. Uses ubws_pkg.
module ubws_ctrl import ubws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{latch: 1'b0, mem_en: 1'b0, mem_we: 1'b0, addr_sel: ADDR_W0,
                   wsel: WSEL_ZERO, cap_lo: 1'b0, cap_hi: 1'b0, out_load: 1'b0,
                   clr_inc: 1'b0};
    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_CLR;
        cmd_o.clr_inc  = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (status_i.in_err) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.mem_en   = 1'b1;
            cmd_o.addr_sel = ADDR_IN;
            state_d        = ST_LO;
          end
        end
      end
      ST_LO: begin
        cmd_o.cap_lo = 1'b1;
        if (status_i.straddle) begin
          cmd_o.mem_en   = 1'b1;
          cmd_o.addr_sel = ADDR_W1;
          state_d        = ST_HI;
        end else begin
          if (status_i.is_write) begin
            cmd_o.mem_en   = 1'b1;
            cmd_o.mem_we   = 1'b1;
            cmd_o.addr_sel = ADDR_W0;
            cmd_o.wsel     = WSEL_LO;
          end
          state_d = ST_DONE;
        end
      end
      ST_HI: begin
        cmd_o.cap_hi = 1'b1;
        if (status_i.is_write) begin
          cmd_o.mem_en   = 1'b1;
          cmd_o.mem_we   = 1'b1;
          cmd_o.addr_sel = ADDR_W0;
          cmd_o.wsel     = WSEL_LO;
          state_d        = ST_WHI;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WHI: begin
        cmd_o.mem_en   = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_W1;
        cmd_o.wsel     = WSEL_HI;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`include "unaligned_byte_addressed_word_store_assert.svh"

  `UBWS_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != ST_IDLE)
  `UBWS_ASSERT_IMPL(a_hi_only_straddle, state_q == ST_HI || state_q == ST_WHI, status_i.straddle)

endmodule

// ----- hw/rtl/unaligned_byte_addressed_word_store.sv -----
// Unaligned byte-addressed word store, 32-bit little-endian, top level.
// Holds one transfer at a time through a single-port word memory: an
// access that stays in one word goes from acceptance to the result
// register by accept and read, capture or write back, load result; a
// straddling access also reads the second word, and a straddling write
// writes back both words in turn, since every word read and every word
// write uses the one memory port. An access past the end does not touch
// the memory. A new item is accepted while the previous result still
// waits to be taken. After reset a clearing pass writes zero to every
// reachable word, min(WORDS, 65) words, before the first item is accepted.
module unaligned_byte_addressed_word_store import ubws_pkg::*; #(
  parameter int WORDS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  ubws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ubws_datapath #(
    .WORDS (WORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/unaligned_byte_addressed_word_store_test.sv -----
// Self-checking bench for the unaligned byte-addressed word store.
// Directed table then random transfers, checked against the table's typed results or a local byte-lane model.
// Depends on ubws_pkg and unaligned_byte_addressed_word_store.
module unaligned_byte_addressed_word_store_test;
  import ubws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS = 64;
  localparam int RANDOM_PER_PHASE = 217;
  localparam int N_ROWS = 25;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_WIDE = 2'd3;

  typedef struct {
    logic              cmd;
    logic [1:0]        size;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    bit                typed;
    logic [DATA_W-1:0] rdata;
    logic              err;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;

  logic [DATA_W-1:0] mirror_words [WORDS];
  out_item_t         pending_results [$];
  int unsigned       error_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;

  // typed rows: after reset, extremes, past-end accesses, write results
  stim_row_t directed_rows [N_ROWS] = '{
    '{CMD_READ,  SIZE_WORD, 8'h00, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_BYTE, 8'hFF, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'hFC, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_WORD, 8'h00, 32'hDEAD_BEEF, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'h00, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_HALF, 8'h01, 32'hFFFF_A55A, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'h00, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_WORD, 8'h02, 32'h1234_5678, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'h01, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_HALF, 8'h03, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_BYTE, 8'hFF, 32'hFFFF_FF80, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_BYTE, 8'hFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_WORD, 8'hFD, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1},
    '{CMD_READ,  SIZE_WORD, 8'hFC, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'hFD, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
    '{CMD_READ,  SIZE_HALF, 8'hFF, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
    '{CMD_WRITE, SIZE_HALF, 8'hFF, 32'h0000_FFFF, 1'b1, 32'h0, 1'b1},
    '{CMD_WRITE, SIZE_HALF, 8'hFE, 32'h7FFF_CAFE, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'hFC, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_WIDE, 8'h06, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WIDE, 8'h05, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_BYTE, 8'h03, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, SIZE_HALF, 8'h7F, 32'h0000_8001, 1'b1, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WORD, 8'h7E, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
    '{CMD_READ,  SIZE_WIDE, 8'hFD, 32'h0000_0000, 1'b1, 32'h0, 1'b1}
  };

  unaligned_byte_addressed_word_store #(
    .WORDS(WORDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    foreach (mirror_words[i]) mirror_words[i] = '0;
  end

  function automatic out_item_t access_result(in_item_t it);
    out_item_t   r;
    int unsigned nbytes;
    int unsigned a;
    int unsigned w;
    int unsigned ln;
    r = '0;
    nbytes = it.access_size[1] ? 4 : ((it.access_size == SIZE_HALF) ? 2 : 1);
    if (int'(it.byte_address) + nbytes > WORDS * LANES) begin
      r.range_error = 1'b1;
      return r;
    end
    for (int i = 0; i < nbytes; i++) begin
      a  = it.byte_address + i;
      w  = (a / LANES) % WORDS;
      ln = a % LANES;
      if (it.cmd == CMD_WRITE) begin
        mirror_words[w][ln*BYTE_W +: BYTE_W] = it.write_data[i*BYTE_W +: BYTE_W];
      end else begin
        r.read_data[i*BYTE_W +: BYTE_W] = mirror_words[w][ln*BYTE_W +: BYTE_W];
      end
    end
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(9);
    it.cmd = 1'($urandom_range(1));
    it.access_size = 2'($urandom_range(3));
    if (pick < 5) begin
      it.byte_address = 8'($urandom_range(255));
    end else if (pick < 8) begin
      it.byte_address = 8'($urandom_range(15));
    end else begin
      it.byte_address = 8'(248 + $urandom_range(7));
    end
    case ($urandom_range(7))
      0: it.write_data = '0;
      1: it.write_data = '1;
      default: it.write_data = $urandom;
    endcase
    return it;
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = access_result(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  // sender holds off until every pending result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result transfer with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.read_data !== want.read_data) begin
          flag_error($sformatf("read_data got %h want %h",
                               out_data_o.read_data, want.read_data));
        end
        if (out_data_o.range_error !== want.range_error) begin
          flag_error($sformatf("range_error got %b want %b",
                               out_data_o.range_error, want.range_error));
        end
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t want;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      it.cmd          = directed_rows[i].cmd;
      it.access_size  = directed_rows[i].size;
      it.byte_address = directed_rows[i].addr;
      it.write_data   = directed_rows[i].data;
      want.read_data  = directed_rows[i].rdata;
      want.range_error = directed_rows[i].err;
      send_item(it, directed_rows[i].typed, want);
    end
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 17; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (RANDOM_PER_PHASE) send_item(rand_item(), 1'b0, '0);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("unaligned_byte_addressed_word_store_test: done, clean");
    end else begin
      $display("unaligned_byte_addressed_word_store_test: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for transfers");
    $display("unaligned_byte_addressed_word_store_test: done, errors");
    $finish;
  end

endmodule
